// ===== rtl/core/rtnr_pkg.sv =====
// Shared constants, register map and level classifier for the radar tile resampler.
package rtnr_pkg;

    localparam int TILE_SIZE_DEF = 256;
    localparam int MAP_WIDTH     = 320;
    localparam int MAP_HEIGHT    = 172;

    localparam int PADDR_W = 5;
    localparam int PDATA_W = 32;

    // register indexes, paddr[4:2]
    localparam logic [2:0] REG_ORIGIN_X = 3'd0;
    localparam logic [2:0] REG_STEP_X   = 3'd1;
    localparam logic [2:0] REG_ORIGIN_Y = 3'd2;
    localparam logic [2:0] REG_STEP_Y   = 3'd3;
    localparam logic [2:0] REG_TILE_X   = 3'd4;
    localparam logic [2:0] REG_TILE_Y   = 3'd5;

    typedef logic [2:0] t_level;

    localparam t_level LVL_NONE = 3'd0;
    localparam t_level LVL_1    = 3'd1;
    localparam t_level LVL_2    = 3'd2;
    localparam t_level LVL_3    = 3'd3;
    localparam t_level LVL_4    = 3'd4;
    localparam t_level LVL_MAX  = 3'd5;

    // palette thresholds on 8-bit channels
    localparam logic [7:0] THR_B_LOW  = 8'd40;
    localparam logic [7:0] THR_R_HIGH = 8'd230;
    localparam logic [7:0] THR_G_LOW  = 8'd100;
    localparam logic [7:0] THR_G_MID  = 8'd190;
    localparam logic [7:0] THR_B_TOP  = 8'd200;
    localparam logic [7:0] THR_B_MID  = 8'd140;

    function automatic t_level classify(input logic [15:0] c565, input logic opq);
        logic [7:0] r;
        logic [7:0] g;
        logic [7:0] b;
        t_level     lvl;
        r = {c565[15:11], 3'b000};
        g = {c565[10:5], 2'b00};
        b = {c565[4:0], 3'b000};
        if (!opq) begin
            lvl = LVL_NONE;
        end else if (b < THR_B_LOW && r > THR_R_HIGH) begin
            if (g < THR_G_LOW) begin
                lvl = LVL_MAX;
            end else if (g < THR_G_MID) begin
                lvl = LVL_4;
            end else begin
                lvl = LVL_3;
            end
        end else if (b > r) begin
            if (b >= THR_B_TOP) begin
                lvl = LVL_1;
            end else if (b >= THR_B_MID) begin
                lvl = LVL_2;
            end else begin
                lvl = LVL_3;
            end
        end else begin
            lvl = LVL_1;
        end
        return lvl;
    endfunction

endpackage

// ===== rtl/core/radar_tile_nearest_resampler.sv =====
// Radar tile resampler: tile level store and nearest-neighbor map lookup.
//
// Usage: items enter on start while busy is low. A load beat (req_type 0)
// classifies one RGB565 tile pixel into a rain level 0..5 and writes it to
// the tile store; loads can follow back to back while busy is low.
// A query beat (req_type 1) names a map pixel. The block raises busy while
// it passes the query through step multiply, position add, tile coordinate
// multiply, store read and level select, and then shows o_in_tile and
// o_rain_level for one cycle with o_valid high. The sequencer carries one
// query through the chain at a time; a new item may be taken in the cycle
// the result is shown.
// Loads never start the query chain, and busy keeps any load off the store
// while a query is in flight. The receiver cannot stall: each result is
// shown for exactly one cycle.
// Configuration goes over the APB port (origin, step, current tile), one
// register per 32-bit word; the user must write them only while the block
// is idle, and the block itself does not enforce this.
// Reset clears the configuration and control registers; the store content is
// undefined until loaded, and a full tile must be loaded before querying.
module radar_tile_nearest_resampler #(
    parameter int TILE_SIZE = rtnr_pkg::TILE_SIZE_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic                         i_req_type,
    input  logic [7:0]                   i_pixel_col,
    input  logic [7:0]                   i_pixel_row,
    input  logic [15:0]                  i_color565,
    input  logic                         i_opaque,
    input  logic [8:0]                   i_map_col,
    input  logic [7:0]                   i_map_row,
    output logic                         o_valid,
    output logic                         o_in_tile,
    output logic [2:0]                   o_rain_level,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [rtnr_pkg::PADDR_W-1:0] paddr,
    input  logic [rtnr_pkg::PDATA_W-1:0] pwdata,
    output logic [rtnr_pkg::PDATA_W-1:0] prdata,
    output logic                         pready
);
    import rtnr_pkg::*;

    localparam int CW    = $clog2(TILE_SIZE);
    localparam int DEPTH = TILE_SIZE * TILE_SIZE;
    localparam int AW    = $clog2(DEPTH);

    localparam logic [8:0]    TS9  = 9'(TILE_SIZE);
    localparam logic [AW-1:0] TS_A = AW'(TILE_SIZE);
    localparam logic [10:0]   MW   = 11'(MAP_WIDTH);
    localparam logic [10:0]   MH   = 11'(MAP_HEIGHT);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_MUL  = 3'd1;
    localparam logic [2:0] ST_POS  = 3'd2;
    localparam logic [2:0] ST_CRD  = 3'd3;
    localparam logic [2:0] ST_ADR  = 3'd4;
    localparam logic [2:0] ST_RD   = 3'd5;
    localparam logic [2:0] ST_OUT  = 3'd6;

    // configuration
    logic [31:0] r_origin_x;
    logic [23:0] r_step_x;
    logic [31:0] r_origin_y;
    logic [23:0] r_step_y;
    logic [7:0]  r_tile_x;
    logic [7:0]  r_tile_y;

    // control
    logic [2:0] r_state;
    logic       r_wr_en;
    logic       r_valid;

    // payload
    logic [AW-1:0] r_wr_addr;
    t_level        r_wr_data;
    logic [8:0]    r_col;
    logic [7:0]    r_row;
    logic          r_in_map;
    logic [33:0]   r_prod_x;
    logic [32:0]   r_prod_y;
    logic          r_hit;
    logic [24:0]   r_frac_x;
    logic [24:0]   r_frac_y;
    logic [CW-1:0] r_cx;
    logic [CW-1:0] r_cy;
    t_level        r_rd;
    logic          r_in_tile;
    t_level        r_level;

    t_level mem [DEPTH];

    logic          accept;
    logic          cfg_wr;
    logic          n_load_ok;
    logic [AW-1:0] n_wr_addr;
    logic          n_in_map;
    logic [33:0]   n_prod_x;
    logic [32:0]   n_prod_y;
    logic [35:0]   n_pos_x;
    logic [35:0]   n_pos_y;
    logic          n_hit;
    logic [33:0]   n_cx_full;
    logic [33:0]   n_cy_full;
    logic [AW-1:0] n_addr;

    assign accept = start && !busy;
    assign busy   = (r_state != ST_IDLE) && (r_state != ST_OUT);
    assign cfg_wr = psel && penable && pwrite && pready;
    assign pready = 1'b1;

    always_comb begin
        case (paddr[4:2])
            REG_ORIGIN_X: prdata = r_origin_x;
            REG_STEP_X:   prdata = {8'd0, r_step_x};
            REG_ORIGIN_Y: prdata = r_origin_y;
            REG_STEP_Y:   prdata = {8'd0, r_step_y};
            REG_TILE_X:   prdata = {24'd0, r_tile_x};
            REG_TILE_Y:   prdata = {24'd0, r_tile_y};
            default:      prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_origin_x <= '0;
            r_step_x   <= '0;
            r_origin_y <= '0;
            r_step_y   <= '0;
            r_tile_x   <= '0;
            r_tile_y   <= '0;
        end else if (cfg_wr) begin
            case (paddr[4:2])
                REG_ORIGIN_X: r_origin_x <= pwdata;
                REG_STEP_X:   r_step_x   <= pwdata[23:0];
                REG_ORIGIN_Y: r_origin_y <= pwdata;
                REG_STEP_Y:   r_step_y   <= pwdata[23:0];
                REG_TILE_X:   r_tile_x   <= pwdata[7:0];
                REG_TILE_Y:   r_tile_y   <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    // load path
    assign n_load_ok = ({1'b0, i_pixel_col} < TS9) && ({1'b0, i_pixel_row} < TS9);
    assign n_wr_addr = AW'(i_pixel_row) * TS_A + AW'(i_pixel_col);

    // query path, pos2 = 2*origin + step*(2*index+1)
    assign n_in_map  = ({2'b00, i_map_col} < MW) && ({3'b000, i_map_row} < MH);
    assign n_prod_x  = 34'(r_step_x) * 34'({r_col, 1'b1});
    assign n_prod_y  = 33'(r_step_y) * 33'({r_row, 1'b1});
    assign n_pos_x   = {3'b000, r_origin_x, 1'b0} + {2'b00, r_prod_x};
    assign n_pos_y   = {3'b000, r_origin_y, 1'b0} + {3'b000, r_prod_y};
    assign n_hit     = r_in_map && (n_pos_x[35:25] == {3'b000, r_tile_x})
                                && (n_pos_y[35:25] == {3'b000, r_tile_y});
    assign n_cx_full = 34'(r_frac_x) * 34'(TS9);
    assign n_cy_full = 34'(r_frac_y) * 34'(TS9);
    assign n_addr    = AW'(r_cy) * TS_A + AW'(r_cx);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_wr_en <= 1'b0;
            r_valid <= 1'b0;
        end else begin
            r_wr_en <= accept && !i_req_type && n_load_ok;
            r_valid <= (r_state == ST_RD);
            case (r_state)
                ST_IDLE, ST_OUT: begin
                    if (accept && i_req_type) begin
                        r_state <= ST_MUL;
                    end else begin
                        r_state <= ST_IDLE;
                    end
                end
                ST_MUL:  r_state <= ST_POS;
                ST_POS:  r_state <= ST_CRD;
                ST_CRD:  r_state <= ST_ADR;
                ST_ADR:  r_state <= ST_RD;
                ST_RD:   r_state <= ST_OUT;
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        r_wr_addr <= n_wr_addr;
        r_wr_data <= classify(i_color565, i_opaque);
        if (accept) begin
            r_col    <= i_map_col;
            r_row    <= i_map_row;
            r_in_map <= n_in_map;
        end
        r_prod_x <= n_prod_x;
        r_prod_y <= n_prod_y;
        r_hit    <= n_hit;
        r_frac_x <= n_pos_x[24:0];
        r_frac_y <= n_pos_y[24:0];
        r_cx     <= n_cx_full[25 +: CW];
        r_cy     <= n_cy_full[25 +: CW];
        if (r_state == ST_RD) begin
            r_in_tile <= r_hit;
            r_level   <= r_hit ? r_rd : LVL_NONE;
        end
    end

    // tile store: one write port for loads, one read port for queries
    always_ff @(posedge i_clk) begin
        if (r_wr_en) begin
            mem[r_wr_addr] <= r_wr_data;
        end
    end

    // read lands in r_rd at the end of the address cycle
    always_ff @(posedge i_clk) begin
        r_rd <= mem[n_addr];
    end

    assign o_valid      = r_valid;
    assign o_in_tile    = r_in_tile;
    assign o_rain_level = r_level;

endmodule

// ===== rtl/core/rtnr_checker.sv =====
// Port-level checks for the radar tile resampler, bound to the top level.
module rtnr_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       start,
    input logic       busy,
    input logic       i_req_type,
    input logic       o_valid,
    input logic       o_in_tile,
    input logic [2:0] o_rain_level
);
    import rtnr_pkg::*;

    a_level_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_rain_level <= LVL_MAX)
        else $error("rain level above range");

    a_outside_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_in_tile |-> o_rain_level == LVL_NONE)
        else $error("nonzero level outside tile");

    a_query_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy && i_req_type |=> busy && !o_valid)
        else $error("query beat did not raise busy");

    a_single_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid)
        else $error("result strobe longer than one cycle");

endmodule

bind radar_tile_nearest_resampler rtnr_checker u_rtnr_checker (.*);
